// ----- hw/rtl/sps_pkg.sv -----
// ---------------------------------------------------------------------------
// sps_pkg
// shared types and constants for the sparse set slot allocator
// ---------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

    localparam int SLOTS = 1024;
    localparam int ID_W  = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RETURN  = 1'b1;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_RELEASED = 2'd1,
        ST_FULL     = 2'd2,
        ST_ABSENT   = 2'd3
    } sps_status_t;

    typedef struct packed {
        logic            action;
        logic [ID_W-1:0] slot_id;
    } sps_cmd_word_t;

    typedef struct packed {
        sps_status_t      status;
        logic [ID_W-1:0]  granted_id;
        logic [ID_W-1:0]  dense_pos;
        logic             moved;
        logic [ID_W-1:0]  move_from;
        logic [ID_W-1:0]  move_to;
        logic [CNT_W-1:0] live_count;
    } sps_result_word_t;

    typedef struct packed {
        logic accept;
        logic clear;
        logic req_fin;
        logic ret_chk;
        logic ret_fin;
    } sps_ctl_t;

    typedef struct packed {
        logic absent;
        logic at_last;
        logic clear_last;
    } sps_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sps_ram.sv -----
// ---------------------------------------------------------------------------
// sps_ram
// generic one-write one-read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sps_ctrl.sv -----
// ---------------------------------------------------------------------------
// sps_ctrl
// sequencer for the clearing pass, requests and returns
// ---------------------------------------------------------------------------
`default_nettype none

module sps_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              action,
    input  wire sps_pkg::sps_sts_t sts,
    output logic                   busy,
    output sps_pkg::sps_ctl_t      ctl
);

    import sps_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REQ,
        S_RET_CHK,
        S_RET_MOVE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.accept = 1'b1;
                    state_next = (action == ACT_RETURN) ? S_RET_CHK : S_REQ;
                end
            end
            S_REQ:
            begin
                ctl.req_fin = 1'b1;
                state_next  = S_IDLE;
            end
            S_RET_CHK:
            begin
                ctl.ret_chk = 1'b1;
                state_next  = (sts.absent || sts.at_last) ? S_IDLE : S_RET_MOVE;
            end
            S_RET_MOVE:
            begin
                ctl.ret_fin = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sps_datapath.sv -----
// ---------------------------------------------------------------------------
// sps_datapath
// id map, reverse map, free stack, counters and result register
// ---------------------------------------------------------------------------
`default_nettype none

module sps_datapath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sps_pkg::sps_cmd_word_t   command,
    input  wire sps_pkg::sps_ctl_t        ctl,
    output sps_pkg::sps_sts_t             sts,
    output sps_pkg::sps_result_word_t     result,
    output logic                          done
);

    import sps_pkg::*;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [ID_W-1:0]  LAST_ADDR = ID_W'(SLOTS - 1);

    logic [CNT_W-1:0] live_reg,  live_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic [ID_W-1:0]  clr_reg,   clr_next;
    logic             done_reg,  done_next;
    sps_result_word_t res_reg,   res_next;
    logic [ID_W-1:0]  id_reg,    id_next;
    logic [ID_W-1:0]  pos_reg,   pos_next;

    logic             map_wr_en;
    logic [ID_W-1:0]  map_wr_addr;
    logic [ID_W:0]    map_wr_data;
    logic [ID_W:0]    map_rd_data;

    logic             rev_wr_en;
    logic [ID_W-1:0]  rev_wr_addr;
    logic [ID_W-1:0]  rev_wr_data;
    logic [ID_W-1:0]  rev_rd_data;

    logic             stk_wr_en;
    logic [ID_W-1:0]  stk_rd_data;

    logic [CNT_W-1:0] live_dec;
    logic [CNT_W-1:0] live_inc;
    logic [CNT_W-1:0] depth_dec;
    logic [ID_W-1:0]  last_pos;
    logic [ID_W-1:0]  found_pos;
    logic             depth_zero;
    logic             req_bad;
    logic [ID_W-1:0]  req_id;
    logic             can_push;

    assign live_dec   = live_reg - 1'b1;
    assign live_inc   = live_reg + 1'b1;
    assign depth_dec  = depth_reg - 1'b1;
    assign last_pos   = live_dec[ID_W-1:0];
    assign found_pos  = map_rd_data[ID_W-1:0];
    assign depth_zero = (depth_reg == '0);
    assign req_bad    = (live_reg >= SLOTS_CNT) || (depth_zero && (fresh_reg >= SLOTS_CNT));
    assign req_id     = depth_zero ? fresh_reg[ID_W-1:0] : stk_rd_data;
    assign can_push   = (depth_reg < SLOTS_CNT);

    assign sts.absent     = !map_rd_data[ID_W] || (live_reg == '0);
    assign sts.at_last    = (found_pos == last_pos);
    assign sts.clear_last = (clr_reg == LAST_ADDR);

    // id map port: clear, grant, invalidate, remap of moved id
    always_comb
    begin
        map_wr_en   = 1'b0;
        map_wr_addr = clr_reg;
        map_wr_data = '0;
        if (ctl.clear)
        begin
            map_wr_en = 1'b1;
        end
        else if (ctl.req_fin && !req_bad)
        begin
            map_wr_en   = 1'b1;
            map_wr_addr = req_id;
            map_wr_data = {1'b1, live_reg[ID_W-1:0]};
        end
        else if (ctl.ret_chk && !sts.absent)
        begin
            map_wr_en   = 1'b1;
            map_wr_addr = id_reg;
        end
        else if (ctl.ret_fin)
        begin
            map_wr_en   = 1'b1;
            map_wr_addr = rev_rd_data;
            map_wr_data = {1'b1, pos_reg};
        end
    end

    always_comb
    begin
        rev_wr_en   = 1'b0;
        rev_wr_addr = live_reg[ID_W-1:0];
        rev_wr_data = req_id;
        if (ctl.req_fin && !req_bad)
        begin
            rev_wr_en = 1'b1;
        end
        else if (ctl.ret_fin)
        begin
            rev_wr_en   = 1'b1;
            rev_wr_addr = pos_reg;
            rev_wr_data = rev_rd_data;
        end
    end

    assign stk_wr_en = ctl.ret_chk && !sts.absent && can_push;

    sps_ram #(.WIDTH(ID_W + 1), .DEPTH(SLOTS)) u_id_map (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (ctl.accept),
        .rd_addr (command.slot_id),
        .rd_data (map_rd_data)
    );

    sps_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_pos_map (
        .clk     (clk),
        .wr_en   (rev_wr_en),
        .wr_addr (rev_wr_addr),
        .wr_data (rev_wr_data),
        .rd_en   (ctl.ret_chk),
        .rd_addr (last_pos),
        .rd_data (rev_rd_data)
    );

    sps_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_free_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (depth_reg[ID_W-1:0]),
        .wr_data (id_reg),
        .rd_en   (ctl.accept),
        .rd_addr (depth_dec[ID_W-1:0]),
        .rd_data (stk_rd_data)
    );

    always_comb
    begin
        live_next  = live_reg;
        depth_next = depth_reg;
        fresh_next = fresh_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        id_next    = id_reg;
        pos_next   = pos_reg;

        if (ctl.clear)
        begin
            clr_next = clr_reg + 1'b1;
        end

        if (ctl.accept)
        begin
            id_next = command.slot_id;
        end

        if (ctl.req_fin)
        begin
            done_next = 1'b1;
            res_next  = '0;
            if (req_bad)
            begin
                res_next.status     = ST_FULL;
                res_next.live_count = live_reg;
            end
            else
            begin
                res_next.status     = ST_GRANTED;
                res_next.granted_id = req_id;
                res_next.dense_pos  = live_reg[ID_W-1:0];
                res_next.live_count = live_inc;
                live_next           = live_inc;
                if (depth_zero)
                begin
                    fresh_next = fresh_reg + 1'b1;
                end
                else
                begin
                    depth_next = depth_dec;
                end
            end
        end

        if (ctl.ret_chk)
        begin
            pos_next = found_pos;
            res_next = '0;
            res_next.granted_id = id_reg;
            if (sts.absent)
            begin
                done_next           = 1'b1;
                res_next.status     = ST_ABSENT;
                res_next.live_count = live_reg;
            end
            else if (sts.at_last)
            begin
                done_next           = 1'b1;
                res_next.status     = ST_RELEASED;
                res_next.dense_pos  = found_pos;
                res_next.live_count = live_dec;
                live_next           = live_dec;
                if (can_push)
                begin
                    depth_next = depth_reg + 1'b1;
                end
            end
        end

        if (ctl.ret_fin)
        begin
            done_next           = 1'b1;
            res_next            = '0;
            res_next.status     = ST_RELEASED;
            res_next.granted_id = id_reg;
            res_next.dense_pos  = pos_reg;
            res_next.moved      = 1'b1;
            res_next.move_from  = last_pos;
            res_next.move_to    = pos_reg;
            res_next.live_count = live_dec;
            live_next           = live_dec;
            if (can_push)
            begin
                depth_next = depth_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= '0;
            depth_reg <= '0;
            fresh_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            live_reg  <= live_next;
            depth_reg <= depth_next;
            fresh_reg <= fresh_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        id_reg  <= id_next;
        pos_reg <= pos_next;
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sparse_set_slot_allocator_top.sv -----
// ---------------------------------------------------------------------------
// sparse_set_slot_allocator_top
// slot allocator with packed dense range and free id stack
//
//   channel   dir   handshake      word
//   command   in    start / busy   sps_cmd_word_t
//   result    out   done strobe    sps_result_word_t
//
// a request passes through accept and S_REQ, a return through accept and
// S_RET_CHK, and also S_RET_MOVE when the last dense entry moves; the chain
// of registered reads of the id map and reverse map sets these steps
// after reset busy stays high during a clearing pass of the id map
// each result shows for one cycle with done; the receiver cannot stall it
// ---------------------------------------------------------------------------
`default_nettype none

module sparse_set_slot_allocator_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire sps_pkg::sps_cmd_word_t    command,
    output logic                           done,
    output sps_pkg::sps_result_word_t      result
);

    import sps_pkg::*;

    sps_ctl_t ctl;
    sps_sts_t sts;

    sps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (command.action),
        .sts    (sts),
        .busy   (busy),
        .ctl    (ctl)
    );

    sps_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (command),
        .ctl     (ctl),
        .sts     (sts),
        .result  (result),
        .done    (done)
    );

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_live_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.live_count <= CNT_W'(SLOTS)))
        else $error("live count beyond slot count");

    a_grant_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_GRANTED)
            |-> (result.live_count == CNT_W'(result.dense_pos) + 1'b1))
        else $error("grant position not at end of dense range");
`endif

endmodule

`default_nettype wire
